// ----- sv/rprop_weight_update_assert.svh -----
// assertion macros shared by the rprop weight update rtl
// expects clk and rst_n in the scope where a macro is used
`ifndef RPROP_WEIGHT_UPDATE_ASSERT_SVH
`define RPROP_WEIGHT_UPDATE_ASSERT_SVH

// condition must hold in the same cycle, checked out of reset
`define RWU_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition must hold in the next cycle, checked out of reset
`define RWU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/rwu_pkg.sv -----
// shared types, constants and helpers for the rprop weight update block
// no dependencies
`default_nettype none

package rwu_pkg;

    localparam int IDX_W      = 12;
    localparam int WGT_W      = 32;
    localparam int STEP_W     = 24;
    localparam int ETA_W      = 16;
    localparam int ETA_FRAC   = 12;
    localparam int SIGN_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    typedef logic [IDX_W-1:0]         idx_t;
    typedef logic signed [WGT_W-1:0]  wgt_t;
    typedef logic [STEP_W-1:0]        step_t;
    typedef logic [ETA_W-1:0]         eta_t;

    // stored gradient sign codes
    typedef enum logic [SIGN_W-1:0] {
        SIGN_ZERO = 2'd0,
        SIGN_POS  = 2'd1,
        SIGN_NEG  = 2'd2
    } sign_t;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STEP_MAX  = 3'd0,
        CFG_STEP_MIN  = 3'd1,
        CFG_INC_ETA   = 3'd2,
        CFG_DEC_ETA   = 3'd3,
        CFG_INIT_STEP = 3'd4
    } cfg_reg_t;

    // item function codes
    localparam logic FUNC_UPDATE = 1'b0;
    localparam logic FUNC_INIT   = 1'b1;

    // register reset values
    localparam step_t STEP_MAX_RST  = 24'd3276800;
    localparam step_t STEP_MIN_RST  = 24'd1;
    localparam eta_t  INC_ETA_RST   = 16'd4915;
    localparam eta_t  DEC_ETA_RST   = 16'd2048;
    localparam step_t INIT_STEP_RST = 24'd6554;

    localparam wgt_t WGT_MAX = 32'sh7FFF_FFFF;
    localparam wgt_t WGT_MIN = 32'sh8000_0000;

    typedef struct packed {
        step_t step_max;
        step_t step_min;
        eta_t  inc_eta;
        eta_t  dec_eta;
        step_t init_step;
    } cfg_t;

    // unused code three reads as zero
    function automatic sign_t decode_sign(input logic [SIGN_W-1:0] raw);
        sign_t s;
        priority if (raw == SIGN_POS)
            s = SIGN_POS;
        else if (raw == SIGN_NEG)
            s = SIGN_NEG;
        else
            s = SIGN_ZERO;
        return s;
    endfunction

    function automatic sign_t sign_of(input wgt_t value);
        sign_t s;
        priority if (value == '0)
            s = SIGN_ZERO;
        else if (value[WGT_W-1])
            s = SIGN_NEG;
        else
            s = SIGN_POS;
        return s;
    endfunction

endpackage

`default_nettype wire

// ----- sv/rwu_step_unit.sv -----
// step size adaptation: scale by growth or shrink factor, saturate, clamp
// depends on rwu_pkg
`default_nettype none

module rwu_step_unit (
    input  rwu_pkg::cfg_t  cfg,
    input  rwu_pkg::sign_t prev_sign,
    input  rwu_pkg::sign_t cur_sign,
    input  rwu_pkg::step_t step_in,
    output rwu_pkg::step_t step_out
);

    localparam int PROD_W   = rwu_pkg::STEP_W + rwu_pkg::ETA_W;
    localparam int SCALED_W = PROD_W - rwu_pkg::ETA_FRAC;

    logic                adjust;
    logic                agree;
    rwu_pkg::eta_t       eta;
    logic [PROD_W-1:0]   product;
    logic [SCALED_W-1:0] scaled;
    rwu_pkg::step_t      scaled_sat;

    always_comb
    begin
        adjust  = (prev_sign != rwu_pkg::SIGN_ZERO) && (cur_sign != rwu_pkg::SIGN_ZERO);
        agree   = (prev_sign == cur_sign);
        eta     = agree ? cfg.inc_eta : cfg.dec_eta;
        product = PROD_W'(step_in) * PROD_W'(eta);
        // drop fraction bits of the factor, truncating
        scaled  = product[PROD_W-1:rwu_pkg::ETA_FRAC];

        if (|scaled[SCALED_W-1:rwu_pkg::STEP_W])
            scaled_sat = '1;
        else
            scaled_sat = scaled[rwu_pkg::STEP_W-1:0];

        priority if (!adjust)
            step_out = step_in;
        else if (agree)
            step_out = (scaled_sat > cfg.step_max) ? cfg.step_max : scaled_sat;
        else
            step_out = (scaled_sat < cfg.step_min) ? cfg.step_min : scaled_sat;
    end

endmodule

`default_nettype wire

// ----- sv/rprop_weight_update.sv -----
// rprop weight update engine top level: pipeline, per-entry state memory, config
// depends on rwu_pkg, rwu_step_unit and rprop_weight_update_assert.svh
`default_nettype none

`include "rprop_weight_update_assert.svh"

// Per-weight rprop update engine. Accepts one transaction per clock while the
// output side keeps ready high and no clearing sweep runs, and returns one
// result transaction per input, in order, through an input register (index
// reduction), a state-read register (the memory read port), a step register
// (the 24x16 multiplier with saturation and clamp) and the output register
// (saturating weight add). Per-entry step and previous sign live in one
// NUM_ENTRIES-deep memory with one read and one write port; the entry written
// by the item just ahead is forwarded, so back-to-back items on the same index
// see fresh state. After reset a clearing sweep zeroes the stored state, one
// entry per cycle; in_ready stays low during it while config writes are taken
// as usual. An update of an entry never initialised sees a zero step and no
// previous sign. Config writes are expected only while the block is idle.
module rprop_weight_update #(
    parameter int NUM_ENTRIES = 4096
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,

    // configuration write port
    input  wire logic                                 cfg_wr_en,
    input  wire logic [rwu_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [rwu_pkg::CFG_DATA_W-1:0]       cfg_data,

    // input transactions
    input  wire logic                                 in_valid,
    output      logic                                 in_ready,
    input  wire logic                                 func,
    input  wire logic [rwu_pkg::IDX_W-1:0]            entry_index,
    input  wire logic signed [rwu_pkg::WGT_W-1:0]     gradient,
    input  wire logic signed [rwu_pkg::WGT_W-1:0]     weight_in,
    input  wire logic                                 frozen,
    input  wire logic                                 force_zero,

    // result transactions
    output      logic                                 out_valid,
    input  wire logic                                 out_ready,
    output      logic signed [rwu_pkg::WGT_W-1:0]     new_weight,
    output      logic [rwu_pkg::STEP_W-1:0]           new_step
);

    localparam int ADDR_W  = $clog2(NUM_ENTRIES);
    localparam int STATE_W = rwu_pkg::SIGN_W + rwu_pkg::STEP_W;
    localparam int EXT_W   = rwu_pkg::WGT_W + 1;
    localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(NUM_ENTRIES - 1);

    typedef logic [ADDR_W-1:0] addr_t;

    // ---------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------
    rwu_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.step_max  <= rwu_pkg::STEP_MAX_RST;
            cfg_reg.step_min  <= rwu_pkg::STEP_MIN_RST;
            cfg_reg.inc_eta   <= rwu_pkg::INC_ETA_RST;
            cfg_reg.dec_eta   <= rwu_pkg::DEC_ETA_RST;
            cfg_reg.init_step <= rwu_pkg::INIT_STEP_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                rwu_pkg::CFG_STEP_MAX:  cfg_reg.step_max  <= cfg_data[rwu_pkg::STEP_W-1:0];
                rwu_pkg::CFG_STEP_MIN:  cfg_reg.step_min  <= cfg_data[rwu_pkg::STEP_W-1:0];
                rwu_pkg::CFG_INC_ETA:   cfg_reg.inc_eta   <= cfg_data[rwu_pkg::ETA_W-1:0];
                rwu_pkg::CFG_DEC_ETA:   cfg_reg.dec_eta   <= cfg_data[rwu_pkg::ETA_W-1:0];
                rwu_pkg::CFG_INIT_STEP: cfg_reg.init_step <= cfg_data[rwu_pkg::STEP_W-1:0];
                default:                ; // unmapped index, write dropped
            endcase
        end
    end

    // ---------------------------------------------------------------
    // pipeline flow control: each stage moves when the next one is
    // empty or moving, so bubbles collapse
    // ---------------------------------------------------------------
    logic s0_valid_reg;
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic out_valid_reg;
    logic clr_busy_reg;

    logic en_out;
    logic en2;
    logic en1;
    logic en0;

    always_comb
    begin
        en_out   = !out_valid_reg || out_ready;
        en2      = !s2_valid_reg || en_out;
        en1      = !s1_valid_reg || en2;
        en0      = !s0_valid_reg || en1;
        in_ready = en0 && !clr_busy_reg;
    end

    // ---------------------------------------------------------------
    // stage 0: input register
    // ---------------------------------------------------------------
    logic           s0_func_reg;
    rwu_pkg::idx_t  s0_index_reg;
    rwu_pkg::wgt_t  s0_grad_reg;
    rwu_pkg::wgt_t  s0_wgt_reg;
    logic           s0_frozen_reg;
    logic           s0_fzero_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_valid_reg <= 1'b0;
        else if (en0)
            s0_valid_reg <= in_valid && !clr_busy_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en0)
        begin
            s0_func_reg   <= func;
            s0_index_reg  <= entry_index;
            s0_grad_reg   <= gradient;
            s0_wgt_reg    <= weight_in;
            s0_frozen_reg <= frozen;
            s0_fzero_reg  <= force_zero;
        end
    end

    // index modulo entry count by compare and subtract of shifted counts;
    // steps whose threshold exceeds the index range fold away
    rwu_pkg::idx_t idx_red;
    addr_t         s0_addr;

    always_comb
    begin
        idx_red = s0_index_reg;
        for (int k = rwu_pkg::IDX_W - 1; k >= 0; k--)
        begin
            if (64'(idx_red) >= (64'(NUM_ENTRIES) << k))
                idx_red = idx_red - rwu_pkg::idx_t'(64'(NUM_ENTRIES) << k);
        end
        s0_addr = addr_t'(idx_red);
    end

    // ---------------------------------------------------------------
    // state memory: {sign, step} per entry
    // ---------------------------------------------------------------
    logic [STATE_W-1:0] state_mem [NUM_ENTRIES];
    logic [STATE_W-1:0] mem_rd_reg;
    logic               mem_we;
    addr_t              mem_waddr;
    logic [STATE_W-1:0] mem_wdata;
    addr_t              clr_cnt_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            state_mem[mem_waddr] <= mem_wdata;
        if (en1)
            mem_rd_reg <= state_mem[s0_addr];
    end

    // clearing sweep after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end
        else if (clr_busy_reg)
        begin
            if (clr_cnt_reg == CLR_LAST)
                clr_busy_reg <= 1'b0;
            else
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    // ---------------------------------------------------------------
    // stage 1: state read, forwarding, step adaptation
    // ---------------------------------------------------------------
    logic           s1_func_reg;
    addr_t          s1_addr_reg;
    rwu_pkg::wgt_t  s1_grad_reg;
    rwu_pkg::wgt_t  s1_wgt_reg;
    logic           s1_frozen_reg;
    logic           s1_fzero_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (en1)
            s1_valid_reg <= s0_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_func_reg   <= s0_func_reg;
            s1_addr_reg   <= s0_addr;
            s1_grad_reg   <= s0_grad_reg;
            s1_wgt_reg    <= s0_wgt_reg;
            s1_frozen_reg <= s0_frozen_reg;
            s1_fzero_reg  <= s0_fzero_reg;
        end
    end

    addr_t          s2_addr_reg;
    rwu_pkg::step_t s2_step_reg;
    rwu_pkg::sign_t s2_sign_reg;
    rwu_pkg::wgt_t  s2_wgt_reg;
    logic           s2_move_reg;

    logic           fwd_hit;
    rwu_pkg::step_t cur_step;
    rwu_pkg::sign_t prev_sign;
    rwu_pkg::sign_t grad_sign;
    rwu_pkg::step_t upd_step;
    rwu_pkg::step_t step_next;
    rwu_pkg::sign_t sign_next;
    rwu_pkg::wgt_t  wgt_next;
    logic           move_next;

    always_comb
    begin
        // stage 2 holds the last writer of its entry
        fwd_hit   = s2_valid_reg && (s2_addr_reg == s1_addr_reg);
        cur_step  = fwd_hit ? s2_step_reg : mem_rd_reg[rwu_pkg::STEP_W-1:0];
        prev_sign = fwd_hit ? s2_sign_reg
                            : rwu_pkg::decode_sign(mem_rd_reg[STATE_W-1:rwu_pkg::STEP_W]);
        grad_sign = rwu_pkg::sign_of(s1_grad_reg);
    end

    rwu_step_unit u_step (
        .cfg       (cfg_reg),
        .prev_sign (prev_sign),
        .cur_sign  (grad_sign),
        .step_in   (cur_step),
        .step_out  (upd_step)
    );

    always_comb
    begin
        priority if (s1_func_reg == rwu_pkg::FUNC_INIT)
        begin
            step_next = cfg_reg.init_step;
            sign_next = rwu_pkg::SIGN_ZERO;
            wgt_next  = '0;
            move_next = 1'b0;
        end
        else if (s1_frozen_reg || s1_fzero_reg)
        begin
            // state written back unchanged
            step_next = cur_step;
            sign_next = prev_sign;
            wgt_next  = s1_fzero_reg ? '0 : s1_wgt_reg;
            move_next = 1'b0;
        end
        else
        begin
            step_next = upd_step;
            sign_next = grad_sign;
            wgt_next  = s1_wgt_reg;
            move_next = (grad_sign != rwu_pkg::SIGN_ZERO);
        end

        // every item writes its entry as it leaves stage 1
        mem_we    = clr_busy_reg || (s1_valid_reg && en2);
        mem_waddr = clr_busy_reg ? clr_cnt_reg : s1_addr_reg;
        mem_wdata = clr_busy_reg ? '0 : {sign_next, step_next};
    end

    // ---------------------------------------------------------------
    // stage 2: saturating weight move
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (en2)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            s2_addr_reg <= s1_addr_reg;
            s2_step_reg <= step_next;
            s2_sign_reg <= sign_next;
            s2_wgt_reg  <= wgt_next;
            s2_move_reg <= move_next;
        end
    end

    logic signed [EXT_W-1:0] w_ext;
    logic signed [EXT_W-1:0] step_ext;
    logic signed [EXT_W-1:0] w_sum;
    rwu_pkg::wgt_t           w_res;

    always_comb
    begin
        w_ext    = {s2_wgt_reg[rwu_pkg::WGT_W-1], s2_wgt_reg};
        step_ext = {{(EXT_W - rwu_pkg::STEP_W){1'b0}}, s2_step_reg};

        priority if (s2_move_reg && (s2_sign_reg == rwu_pkg::SIGN_NEG))
            w_sum = w_ext - step_ext;
        else if (s2_move_reg)
            w_sum = w_ext + step_ext;
        else
            w_sum = w_ext;

        // overflow when the two top bits disagree
        if (w_sum[EXT_W-1] != w_sum[EXT_W-2])
            w_res = w_sum[EXT_W-1] ? rwu_pkg::WGT_MIN : rwu_pkg::WGT_MAX;
        else
            w_res = w_sum[rwu_pkg::WGT_W-1:0];
    end

    // ---------------------------------------------------------------
    // output register
    // ---------------------------------------------------------------
    rwu_pkg::wgt_t  new_weight_reg;
    rwu_pkg::step_t new_step_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en_out)
            out_valid_reg <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en_out)
        begin
            new_weight_reg <= w_res;
            new_step_reg   <= s2_step_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign new_weight = new_weight_reg;
    assign new_step   = new_step_reg;

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------
    `RWU_ASSERT_SAME(a_clear_blocks_input, clr_busy_reg, !in_ready, "input taken during state clear")
    `RWU_ASSERT_SAME(a_clear_pipe_empty, clr_busy_reg, !(s0_valid_reg || s1_valid_reg || s2_valid_reg), "pipeline busy during state clear")
    `RWU_ASSERT_NEXT(a_clear_continues, clr_busy_reg && (clr_cnt_reg != CLR_LAST), clr_busy_reg, "state clear ended early")
    `RWU_ASSERT_NEXT(a_stage2_holds, s2_valid_reg && !en_out, s2_valid_reg, "stage 2 transaction lost while output stalled")

endmodule

`default_nettype wire

// ----- tb/sv/rwu_update_checker.sv -----
`timescale 1ns / 1ps
// rprop weight update checker: follows the config port and both channels,
// computes every result from its own per-entry state and compares in order
// depends on rwu_pkg
module rwu_update_checker
    import rwu_pkg::*;
#(
    parameter int NUM_ENTRIES = 4096
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  logic                  func,
    input  idx_t                  entry_index,
    input  wgt_t                  gradient,
    input  wgt_t                  weight_in,
    input  logic                  frozen,
    input  logic                  force_zero,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  wgt_t                  new_weight,
    input  step_t                 new_step,
    output int                    error_count,
    output int                    in_flight
);

    typedef struct packed {
        wgt_t  weight;
        step_t step;
    } weight_step_t;

    weight_step_t weight_step_q[$];
    step_t        entry_step [NUM_ENTRIES];
    sign_t        entry_sign [NUM_ENTRIES];
    cfg_t         regs;
    int           errors = 0;

    // step * eta in Q4.12, truncated, saturated to the step width
    function automatic step_t scaled_step(input step_t s, input eta_t eta);
        logic [STEP_W+ETA_W-1:0] prod;
        prod = s * eta;
        prod = prod >> ETA_FRAC;
        if (prod[STEP_W+ETA_W-1:STEP_W] != '0)
            return '1;
        return prod[STEP_W-1:0];
    endfunction

    function automatic wgt_t moved_weight(input wgt_t w, input step_t s, input sign_t dir);
        logic signed [WGT_W+1:0] sum;
        logic signed [WGT_W+1:0] delta;
        sum   = w;
        delta = {{(WGT_W+2-STEP_W){1'b0}}, s};
        if (dir == SIGN_POS)
            sum = sum + delta;
        else if (dir == SIGN_NEG)
            sum = sum - delta;
        if (sum > WGT_MAX)
            return WGT_MAX;
        if (sum < WGT_MIN)
            return WGT_MIN;
        return sum[WGT_W-1:0];
    endfunction

    // one rprop step on the local entry state
    function automatic weight_step_t apply_rprop(input logic fn, input idx_t raw_idx,
                                                 input wgt_t grad, input wgt_t wgt,
                                                 input logic frz, input logic fz);
        int           idx;
        step_t        step;
        sign_t        prev;
        sign_t        cur;
        weight_step_t r;
        idx = int'(raw_idx) % NUM_ENTRIES;
        if (fn == FUNC_INIT)
        begin
            entry_step[idx] = regs.init_step;
            entry_sign[idx] = SIGN_ZERO;
            r.weight = '0;
            r.step   = regs.init_step;
            return r;
        end
        step = entry_step[idx];
        if (frz || fz)
        begin
            r.weight = fz ? wgt_t'(0) : wgt;
            r.step   = step;
            return r;
        end
        prev = entry_sign[idx];
        if (grad == '0)
            cur = SIGN_ZERO;
        else if (grad[WGT_W-1])
            cur = SIGN_NEG;
        else
            cur = SIGN_POS;
        if (prev != SIGN_ZERO && cur != SIGN_ZERO)
        begin
            if (prev == cur)
            begin
                step = scaled_step(step, regs.inc_eta);
                if (step > regs.step_max)
                    step = regs.step_max;
            end
            else
            begin
                step = scaled_step(step, regs.dec_eta);
                if (step < regs.step_min)
                    step = regs.step_min;
            end
        end
        entry_step[idx] = step;
        entry_sign[idx] = cur;
        r.weight = moved_weight(wgt, step, cur);
        r.step   = step;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        weight_step_t oldest;
        if (!rst_n)
        begin
            regs.step_max  = STEP_MAX_RST;
            regs.step_min  = STEP_MIN_RST;
            regs.inc_eta   = INC_ETA_RST;
            regs.dec_eta   = DEC_ETA_RST;
            regs.init_step = INIT_STEP_RST;
            for (int i = 0; i < NUM_ENTRIES; i++)
            begin
                entry_step[i] = '0;
                entry_sign[i] = SIGN_ZERO;
            end
            weight_step_q.delete();
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_STEP_MAX:  regs.step_max  = cfg_data[STEP_W-1:0];
                    CFG_STEP_MIN:  regs.step_min  = cfg_data[STEP_W-1:0];
                    CFG_INC_ETA:   regs.inc_eta   = cfg_data[ETA_W-1:0];
                    CFG_DEC_ETA:   regs.dec_eta   = cfg_data[ETA_W-1:0];
                    CFG_INIT_STEP: regs.init_step = cfg_data[STEP_W-1:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                weight_step_q.push_back(apply_rprop(func, entry_index, gradient, weight_in,
                                                    frozen, force_zero));
            if (out_valid && out_ready)
            begin
                if (weight_step_q.size() == 0)
                begin
                    $display("%0t: unrequested result, expected none, actual weight %h step %h",
                             $time, new_weight, new_step);
                    errors++;
                end
                else
                begin
                    oldest = weight_step_q.pop_front();
                    if (new_weight !== oldest.weight)
                    begin
                        $display("%0t: new_weight mismatch, expected %h, actual %h",
                                 $time, oldest.weight, new_weight);
                        errors++;
                    end
                    if (new_step !== oldest.step)
                    begin
                        $display("%0t: new_step mismatch, expected %h, actual %h",
                                 $time, oldest.step, new_step);
                        errors++;
                    end
                end
            end
        end
        error_count <= errors;
        in_flight   <= weight_step_q.size();
    end

endmodule

// ----- tb/sv/tb_rprop_weight_update.sv -----
`timescale 1ns / 1ps
// top of the rprop weight update testbench: clock, reset, stimulus, verdict
// depends on rwu_pkg, rprop_weight_update and rwu_update_checker
module tb_rprop_weight_update;
    import rwu_pkg::*;

    localparam int NUM_ENTRIES     = 4096;
    localparam int HALF_PERIOD     = 2;
    localparam int RESET_CYCLES    = 9;
    localparam int SETTLE_CYCLES   = 8;      // pipeline is four deep, leave some margin
    localparam int HOLD_CYCLES     = 300;    // long receiver hold-off
    localparam int PRESSURE_ITEMS  = 48;     // back-to-back items sent during a hold-off
    localparam int RANDOM_PHASES   = 6;
    localparam int ITEMS_PER_PHASE = 205;
    localparam int TIMEOUT_NS      = 2_000_000;

    typedef struct packed {
        logic fn;
        idx_t idx;
        wgt_t grad;
        wgt_t wgt;
        logic frz;
        logic fz;
    } weight_txn_t;

    // receiver behavior modes
    typedef enum int {
        RX_OPEN,
        RX_BUSY,
        RX_CHOKED,
        RX_CADENCE
    } rx_mode_t;

    logic                  clk         = 1'b0;
    logic                  rst_n       = 1'b0;
    logic                  cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [CFG_DATA_W-1:0] cfg_data    = '0;
    logic                  in_valid    = 1'b0;
    logic                  in_ready;
    logic                  func        = FUNC_UPDATE;
    idx_t                  entry_index = '0;
    wgt_t                  gradient    = '0;
    wgt_t                  weight_in   = '0;
    logic                  frozen      = 1'b0;
    logic                  force_zero  = 1'b0;
    logic                  out_valid;
    logic                  out_ready   = 1'b0;
    wgt_t                  new_weight;
    step_t                 new_step;
    int                    error_count;
    int                    in_flight;

    // entries that have seen an initialise transaction; updates go only there
    bit   entry_live    [NUM_ENTRIES];
    // sign of the last gradient sent per entry, used to build agreeing runs
    bit   last_grad_neg [NUM_ENTRIES];
    idx_t hot_base      = '0;
    int   burst_left    = 0;
    int   hold_requests = 0;
    int   hold_served   = 0;

    rprop_weight_update #(
        .NUM_ENTRIES (NUM_ENTRIES)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .func        (func),
        .entry_index (entry_index),
        .gradient    (gradient),
        .weight_in   (weight_in),
        .frozen      (frozen),
        .force_zero  (force_zero),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .new_weight  (new_weight),
        .new_step    (new_step)
    );

    // watches both channels and the config port, owns all comparisons
    rwu_update_checker #(
        .NUM_ENTRIES (NUM_ENTRIES)
    ) u_check (.*);

    // 4 ns clock
    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    function automatic weight_txn_t make_txn(input logic fn, input idx_t idx, input wgt_t grad,
                                             input wgt_t wgt, input logic frz, input logic fz);
        weight_txn_t t;
        t.fn   = fn;
        t.idx  = idx;
        t.grad = grad;
        t.wgt  = wgt;
        t.frz  = frz;
        t.fz   = fz;
        return t;
    endfunction

    // drive at the falling edge, hold until the block takes the transaction
    task automatic send(input weight_txn_t t);
        @(negedge clk);
        in_valid    <= 1'b1;
        func        <= t.fn;
        entry_index <= t.idx;
        gradient    <= t.grad;
        weight_in   <= t.wgt;
        frozen      <= t.frz;
        force_zero  <= t.fz;
        if (t.fn == FUNC_INIT)
            entry_live[t.idx] = 1'b1;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
    endtask

    task automatic idle(input int n);
        repeat (n)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
    endtask

    // sender pauses until every result is back, then lets the pipe settle
    task automatic drain();
        idle(1);
        while (in_flight != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] r, input logic [CFG_DATA_W-1:0] v);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= r;
        cfg_data  <= v;
    endtask

    // full register set; eta writes carry junk in the unused upper bits
    task automatic program_regs(input step_t mx, input step_t mn, input eta_t inc,
                                input eta_t dec, input step_t init, input bit touch_unused);
        logic [CFG_DATA_W-ETA_W-1:0] pad;
        pad = (CFG_DATA_W-ETA_W)'($urandom);
        write_reg(CFG_STEP_MAX, mx);
        write_reg(CFG_STEP_MIN, mn);
        write_reg(CFG_INC_ETA, {pad, inc});
        write_reg(CFG_DEC_ETA, {~pad, dec});
        write_reg(CFG_INIT_STEP, init);
        // indexes past the last register must be ignored
        if (touch_unused)
            for (int k = int'(CFG_INIT_STEP) + 1; k < 2**CFG_IDX_W; k++)
                write_reg((CFG_IDX_W)'(k), (CFG_DATA_W)'($urandom));
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // mostly well-formed traffic: init an entry, then runs of updates whose
    // gradient sign tends to repeat, with flips, zeros and extremes mixed in
    task automatic random_txn(output weight_txn_t t);
        idx_t             idx;
        logic [WGT_W-1:0] mag;
        logic             neg;
        int               pick;
        if ($urandom_range(0, 9) < 7)
            idx = hot_base + idx_t'($urandom_range(0, 15));
        else
            idx = idx_t'($urandom_range(0, NUM_ENTRIES - 1));
        t = make_txn(FUNC_INIT, idx, wgt_t'($urandom), wgt_t'($urandom),
                     ($urandom_range(0, 11) == 0), ($urandom_range(0, 11) == 0));
        if (entry_live[idx] && $urandom_range(0, 9) != 0)
        begin
            t.fn = FUNC_UPDATE;
            case ($urandom_range(0, 2))
                0:       mag = $urandom_range(1, 65535);
                1:       mag = {1'b0, 31'($urandom)};
                default: mag = 32'd1 << $urandom_range(0, 30);
            endcase
            if (mag == '0)
                mag = 32'd1;
            pick = $urandom_range(0, 99);
            neg  = (pick < 55) ? last_grad_neg[idx] : !last_grad_neg[idx];
            if (pick < 85)
                t.grad = neg ? wgt_t'(32'd0 - mag) : wgt_t'(mag);
            else if (pick < 93)
                t.grad = '0;
            else
            begin
                case ($urandom_range(0, 3))
                    0:       t.grad = WGT_MIN;
                    1:       t.grad = WGT_MAX;
                    2:       t.grad = 32'sd1;
                    default: t.grad = -32'sd1;
                endcase
            end
            if (t.grad != '0)
                last_grad_neg[idx] = t.grad[WGT_W-1];
            // push some weights close to the saturation limits
            pick = $urandom_range(0, 99);
            if (pick >= 85)
                t.wgt = WGT_MIN + wgt_t'($urandom_range(0, 65535));
            else if (pick >= 70)
                t.wgt = WGT_MAX - wgt_t'($urandom_range(0, 65535));
        end
    endtask

    // receiver: ready pattern of its own, switching mode every so often,
    // plus long hold-offs on request from the stimulus
    initial
    begin : receiver
        rx_mode_t mode;
        int       mode_left;
        int       hold_left;
        int       cyc;
        mode      = RX_OPEN;
        mode_left = 0;
        hold_left = 0;
        cyc       = 0;
        forever
        begin
            @(negedge clk);
            cyc++;
            if (hold_requests != hold_served)
            begin
                hold_served++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = rx_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(10, 150);
                end
                mode_left--;
                case (mode)
                    RX_OPEN:   out_ready <= 1'b1;
                    RX_BUSY:   out_ready <= ($urandom_range(0, 3) != 0);
                    RX_CHOKED: out_ready <= ($urandom_range(0, 2) == 0);
                    default:   out_ready <= ((cyc % 5) < 3);
                endcase
            end
        end
    end

    initial
    begin : stimulus
        weight_txn_t t;
        int          gap;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        // directed part under reset settings; the first transaction waits out
        // the state clearing sweep through in_ready
        send(make_txn(FUNC_INIT, 12'd0, 32'sh1234_5678, 32'sh7654_3210, 1'b1, 1'b1));
        send(make_txn(FUNC_INIT, idx_t'(NUM_ENTRIES - 1), '0, '0, 1'b0, 1'b0));
        send(make_txn(FUNC_INIT, 12'd1, '0, '0, 1'b0, 1'b0));
        // no previous sign: step kept
        send(make_txn(FUNC_UPDATE, 12'd0, 32'sh0001_0000, 32'sh0001_0000, 1'b0, 1'b0));
        // same sign: grow
        send(make_txn(FUNC_UPDATE, 12'd0, 32'sd5, 32'sh0001_0000, 1'b0, 1'b0));
        // opposite sign: shrink
        send(make_txn(FUNC_UPDATE, 12'd0, -32'sh0002_0000, 32'sh0003_0000, 1'b0, 1'b0));
        // zero gradient: step kept, weight unchanged, sign cleared
        send(make_txn(FUNC_UPDATE, 12'd0, '0, -32'sh0000_1234, 1'b0, 1'b0));
        send(make_txn(FUNC_UPDATE, 12'd0, WGT_MIN, '0, 1'b0, 1'b0));
        send(make_txn(FUNC_UPDATE, 12'd0, -32'sd1, '0, 1'b0, 1'b0));
        // weight saturation at both ends
        send(make_txn(FUNC_UPDATE, idx_t'(NUM_ENTRIES - 1), WGT_MAX, WGT_MAX, 1'b0, 1'b0));
        send(make_txn(FUNC_UPDATE, idx_t'(NUM_ENTRIES - 1), WGT_MAX, WGT_MAX - 3, 1'b0, 1'b0));
        send(make_txn(FUNC_UPDATE, idx_t'(NUM_ENTRIES - 1), WGT_MIN, WGT_MIN, 1'b0, 1'b0));
        // frozen, frozen with force zero, force zero alone: state untouched
        send(make_txn(FUNC_UPDATE, 12'd1, 32'sh0000_0100, 32'sh1234_5678, 1'b1, 1'b0));
        send(make_txn(FUNC_UPDATE, 12'd1, 32'sh0000_0100, 32'sh1234_5678, 1'b1, 1'b1));
        send(make_txn(FUNC_UPDATE, 12'd1, -32'sh0000_0100, 32'sh1234_5678, 1'b0, 1'b1));
        send(make_txn(FUNC_UPDATE, 12'd1, 32'sh0000_0100, 32'sh1234_5678, 1'b0, 1'b0));
        // re-initialise clears the stored sign
        send(make_txn(FUNC_INIT, 12'd1, 32'sh0000_0100, '0, 1'b0, 1'b0));
        send(make_txn(FUNC_UPDATE, 12'd1, 32'sh0000_0100, '0, 1'b0, 1'b0));

        // high extremes: product saturates, shrink collapses the step to zero
        drain();
        program_regs('1, '0, '1, '0, '1, 1'b1);
        send(make_txn(FUNC_INIT, 12'd2, '0, '0, 1'b0, 1'b0));
        send(make_txn(FUNC_UPDATE, 12'd2, 32'sd1, '0, 1'b0, 1'b0));
        send(make_txn(FUNC_UPDATE, 12'd2, WGT_MAX, WGT_MAX, 1'b0, 1'b0));
        send(make_txn(FUNC_UPDATE, 12'd2, -32'sd1, WGT_MIN, 1'b0, 1'b0));
        send(make_txn(FUNC_UPDATE, 12'd2, -32'sd1, 32'sh0abc_def0, 1'b0, 1'b0));
        send(make_txn(FUNC_INIT, 12'd3, '0, '0, 1'b1, 1'b1));
        send(make_txn(FUNC_UPDATE, 12'd3, WGT_MIN, WGT_MIN, 1'b0, 1'b0));

        // random phases, each under its own register setting
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            drain();
            case (p)
                0: program_regs(STEP_MAX_RST, STEP_MIN_RST, INC_ETA_RST, DEC_ETA_RST,
                                INIT_STEP_RST, 1'b0);
                1: program_regs('1, '0, '1, '0, '1, 1'b0);
                // crossed limits: cap at zero, floor at the top
                2: program_regs('0, '1, '0, '1, '0, 1'b1);
                3: program_regs(step_t'($urandom), step_t'($urandom), eta_t'($urandom),
                                eta_t'($urandom), step_t'($urandom), 1'b1);
                4: program_regs(step_t'($urandom_range(65536, 24'hFF_FFFF)),
                                step_t'($urandom_range(0, 64)),
                                eta_t'($urandom_range(4096, 8192)),
                                eta_t'($urandom_range(1024, 4095)),
                                step_t'($urandom_range(1, 262144)), 1'b0);
                // inverted factors: agreement never grows, disagreement never shrinks
                default: program_regs(step_t'($urandom), step_t'($urandom_range(0, 255)),
                                      eta_t'($urandom_range(0, 4096)),
                                      eta_t'($urandom_range(4096, 65535)),
                                      step_t'($urandom_range(0, 65535)), 1'b0);
            endcase
            hot_base   = idx_t'($urandom_range(0, NUM_ENTRIES - 16));
            burst_left = 0;
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                // receiver holds off while the sender keeps offering back to back,
                // so the pipe fills and in_ready drops
                if ((p == 2 || p == 4) && n == ITEMS_PER_PHASE / 2)
                begin
                    hold_requests++;
                    repeat (PRESSURE_ITEMS)
                    begin
                        random_txn(t);
                        send(t);
                    end
                end
                if (burst_left == 0)
                begin
                    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    if (gap > 0)
                        idle(gap);
                    burst_left = $urandom_range(1, 24);
                end
                burst_left--;
                if ($urandom_range(0, 49) == 0)
                    hot_base = idx_t'($urandom_range(0, NUM_ENTRIES - 16));
                random_txn(t);
                send(t);
            end
        end

        drain();
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // hard stop for a hung handshake
    initial
    begin : watchdog
        #(TIMEOUT_NS);
        $display("tb: failure");
        $finish;
    end

endmodule
